// File: rtl/core/ffba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned BitW   = 5;
  localparam int unsigned SizeW  = 11;
  localparam int unsigned AddrW  = 10;

  // request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [SizeW-1:0] size;
    logic [AddrW-1:0] start_address;
  } ffba_req_t;

  typedef struct packed {
    logic             ok;
    logic [AddrW-1:0] block_address;
  } ffba_rsp_t;

endpackage

// File: rtl/core/ffba_word_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_word_scan
// Finds where a free run reaches the requested length inside one map word.
// ----------------------------------------------------------------------------
module ffba_word_scan
  import ffba_pkg::*;
#(
  parameter int unsigned CntW = 11
) (
  input  logic [WordW-1:0] free_i,
  input  logic [CntW-1:0]  run_i,
  input  logic [CntW-1:0]  len_i,
  output logic             hit_o,
  output logic [BitW-1:0]  pos_o,
  output logic [CntW-1:0]  run_o
);

  localparam int unsigned ExtW = CntW + BitW + 1;

  logic [ExtW-1:0]  total [WordW];
  logic [WordW-1:0] hit_vec;

  // run length ending at each bit, carried run included when the word prefix is free
  always_comb begin
    logic [BitW-1:0] lz;
    logic            anyz;
    for (int i = 0; i < WordW; i++) begin
      lz   = '0;
      anyz = 1'b0;
      for (int j = 0; j <= i; j++) begin
        if (!free_i[j]) begin
          lz   = BitW'(j);
          anyz = 1'b1;
        end
      end
      if (anyz) begin
        total[i] = ExtW'(BitW'(i) - lz);
      end else begin
        total[i] = ExtW'(run_i) + ExtW'(i + 1);
      end
      hit_vec[i] = (total[i] >= ExtW'(len_i));
    end
  end

  // lowest bit where the run completes
  always_comb begin
    pos_o = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        pos_o = BitW'(i);
      end
    end
  end

  assign hit_o = |hit_vec;
  assign run_o = total[WordW-1][CntW-1:0];

endmodule

// File: rtl/core/first_fit_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator of contiguous unit runs over a one-bit occupancy map.
// ----------------------------------------------------------------------------
// Usage:
//   A request (allocate or free) is taken when start is high and busy is low.
//   Exactly one response follows, shown for one cycle with done_o high; the
//   receiver cannot hold it off. busy stays high until that response cycle;
//   requests answered at once never raise it.
//   The map lives in a 32-bit wide memory of ceil(MEMORY_UNITS/32) words.
//   Allocate scans one word per cycle from word 0 (registered read)
//   and then sweeps the covered words read-modify-write, one word per cycle.
//   A failed allocate scans every word of the map.
//   A free sweeps only the covered words.
//   Zero-size or out-of-range requests are answered straight from idle.
//   After reset the block clears the map, one word per cycle, with busy high.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int unsigned MEMORY_UNITS = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  ffba_req_t req_i,
  output logic      done_o,
  output ffba_rsp_t rsp_o
);

  localparam int unsigned Words = (MEMORY_UNITS + WordW - 1) / WordW;
  localparam int unsigned UaW   = $clog2(MEMORY_UNITS);
  localparam int unsigned WaW   = (UaW > BitW) ? UaW - BitW : 1;
  localparam int unsigned CntW  = $clog2(MEMORY_UNITS + 1);
  localparam int unsigned UW    = $clog2(Words * WordW + 4096) + 1;

  localparam logic [1:0] ST_CLR   = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_SWEEP = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [WaW:0]     iss_q, iss_d;
  logic [WaW-1:0]   ev_q, ev_d;
  logic             dv_q, dv_d;
  logic [CntW-1:0]  run_q, run_d;
  logic [CntW-1:0]  len_q, len_d;
  logic [UaW-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic             set_q, set_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic             done_q, done_d;
  ffba_rsp_t        rsp_q, rsp_d;

  logic [WordW-1:0] mem [Words];
  logic [WordW-1:0] rdata_q;
  logic [WaW-1:0]   raddr, waddr;
  logic             we;
  logic [WordW-1:0] wdata;

  logic [UW-1:0]    base, lo_x, hi_x, size_x, start_x, end_x, at_x;
  logic [WordW-1:0] vmask, wmask, free_w;
  logic [BitW-1:0]  lo_b, hi_b, pos;
  logic             hit;
  logic [CntW-1:0]  run_nx;

  // map memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // word geometry of the word under evaluation
  assign base    = UW'(ev_q) << BitW;
  assign lo_x    = UW'(lo_q);
  assign hi_x    = UW'(hi_q);
  assign size_x  = UW'(req_i.size);
  assign start_x = UW'(req_i.start_address);
  assign end_x   = start_x + size_x - UW'(1);

  always_comb begin
    for (int i = 0; i < WordW; i++) begin
      vmask[i] = ((base + UW'(i)) < UW'(MEMORY_UNITS));
    end
  end
  assign free_w = ~rdata_q & vmask;

  // run mask of the word being swept
  assign lo_b  = (UW'(ev_q) == (lo_x >> BitW)) ? lo_x[BitW-1:0] : '0;
  assign hi_b  = (UW'(ev_q) == (hi_x >> BitW)) ? hi_x[BitW-1:0] : BitW'(WordW - 1);
  assign wmask = ({WordW{1'b1}} << lo_b) & ({WordW{1'b1}} >> (BitW'(WordW - 1) - hi_b));

  ffba_word_scan #(
    .CntW(CntW)
  ) u_scan (
    .free_i(free_w),
    .run_i (run_q),
    .len_i (len_q),
    .hit_o (hit),
    .pos_o (pos),
    .run_o (run_nx)
  );

  assign at_x = base + UW'(pos) + UW'(1) - UW'(len_q);

  // request sequencer
  always_comb begin
    state_d = state_q;
    iss_d   = iss_q;
    ev_d    = ev_q;
    dv_d    = 1'b0;
    run_d   = run_q;
    len_d   = len_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    set_d   = set_q;
    addr_d  = addr_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    raddr   = iss_q[WaW-1:0];
    waddr   = ev_q;
    we      = 1'b0;
    wdata   = set_q ? (rdata_q | wmask) : (rdata_q & ~wmask);
    unique case (state_q)
      ST_CLR: begin
        we    = 1'b1;
        waddr = iss_q[WaW-1:0];
        wdata = '0;
        iss_d = iss_q + 1'b1;
        if (iss_q == (WaW+1)'(Words - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (req_i.req_type == REQ_ALLOC) begin
            if (req_i.size == '0) begin
              done_d = 1'b1;
              rsp_d  = '{ok: 1'b1, block_address: '0};
            end else if (size_x > UW'(MEMORY_UNITS)) begin
              done_d = 1'b1;
              rsp_d  = '{ok: 1'b0, block_address: '0};
            end else begin
              len_d   = CntW'(size_x);
              run_d   = '0;
              iss_d   = '0;
              state_d = ST_SCAN;
            end
          end else begin
            addr_d = req_i.start_address;
            if (req_i.size == '0 || start_x >= UW'(MEMORY_UNITS)) begin
              done_d = 1'b1;
              rsp_d  = '{ok: 1'b1, block_address: req_i.start_address};
            end else begin
              lo_d    = UaW'(start_x);
              hi_d    = (end_x >= UW'(MEMORY_UNITS)) ? UaW'(MEMORY_UNITS - 1) : UaW'(end_x);
              set_d   = 1'b0;
              iss_d   = (WaW+1)'(start_x >> BitW);
              state_d = ST_SWEEP;
            end
          end
        end
      end
      ST_SCAN: begin
        if (iss_q < (WaW+1)'(Words)) begin
          iss_d = iss_q + 1'b1;
          dv_d  = 1'b1;
          ev_d  = iss_q[WaW-1:0];
        end
        if (dv_q) begin
          if (hit) begin
            lo_d    = UaW'(at_x);
            hi_d    = UaW'(base + UW'(pos));
            set_d   = 1'b1;
            addr_d  = at_x[AddrW-1:0];
            iss_d   = (WaW+1)'(at_x >> BitW);
            dv_d    = 1'b0;
            state_d = ST_SWEEP;
          end else if (ev_q == WaW'(Words - 1)) begin
            dv_d    = 1'b0;
            done_d  = 1'b1;
            rsp_d   = '{ok: 1'b0, block_address: '0};
            state_d = ST_IDLE;
          end else begin
            run_d = run_nx;
          end
        end
      end
      ST_SWEEP: begin
        if (UW'(iss_q) <= (hi_x >> BitW)) begin
          iss_d = iss_q + 1'b1;
          dv_d  = 1'b1;
          ev_d  = iss_q[WaW-1:0];
        end
        if (dv_q) begin
          we = 1'b1;
          if (UW'(ev_q) == (hi_x >> BitW)) begin
            dv_d    = 1'b0;
            done_d  = 1'b1;
            rsp_d   = '{ok: 1'b1, block_address: addr_q};
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      iss_q   <= '0;
      dv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      iss_q   <= iss_d;
      dv_q    <= dv_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ev_q   <= ev_d;
    run_q  <= run_d;
    len_q  <= len_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    set_q  <= set_d;
    addr_q <= addr_d;
    rsp_q  <= rsp_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // checks
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy) || $past(start))
    else $error("response without a request");

  a_fail_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !rsp_o.ok |-> rsp_o.block_address == '0)
    else $error("failed allocate with nonzero address");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !we)
    else $error("map write while idle");

  a_sweep_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SWEEP |-> lo_q <= hi_q)
    else $error("sweep range reversed");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit block allocator: directed corner
// requests, then random allocate/free traffic with random start gaps; every
// response is compared with a behavioral occupancy-map predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import ffba_pkg::*;

  localparam int unsigned Units    = 1024;
  localparam int unsigned MaxCycle = 1000000;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  ffba_req_t req_i;
  logic      done_o;
  ffba_rsp_t rsp_o;

  first_fit_block_allocator #(.MEMORY_UNITS(Units)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  ffba_req_t   pending_reqs[$];
  ffba_rsp_t   expected_rsps[$];
  bit          occupancy[Units];
  int unsigned err_count;
  int unsigned cycle_count;
  bit          stim_done;
  int unsigned gap_left;

  // sampled handshake state at the rising edge
  logic busy_q;
  initial busy_q = 1'b1;

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    err_count++;
  endtask

  // first-fit occupancy predictor
  function automatic ffba_rsp_t predict_alloc(input ffba_req_t r);
    ffba_rsp_t   rsp;
    int unsigned len;
    int unsigned run;
    int unsigned base;
    len = r.size;
    rsp = '0;
    run = 0;
    if (r.req_type == REQ_FREE) begin
      for (int unsigned u = 0; u < len; u++) begin
        if (r.start_address + u >= Units) break;
        occupancy[r.start_address + u] = 1'b0;
      end
      rsp.ok = 1'b1;
      rsp.block_address = r.start_address;
    end else if (len == 0) begin
      rsp.ok = 1'b1;
    end else if (len <= Units) begin
      for (int unsigned u = 0; u < Units; u++) begin
        if (occupancy[u]) run = 0;
        else begin
          run++;
          if (run == len) begin
            base = u + 1 - len;
            for (int unsigned k = 0; k < len; k++) occupancy[base + k] = 1'b1;
            rsp.ok = 1'b1;
            rsp.block_address = base[AddrW-1:0];
            break;
          end
        end
      end
    end
    return rsp;
  endfunction

  function automatic ffba_req_t mk_req(input logic kind, input int unsigned sz,
                                       input int unsigned addr);
    ffba_req_t r;
    r.req_type = kind;
    r.size = sz[SizeW-1:0];
    r.start_address = addr[AddrW-1:0];
    return r;
  endfunction

  function automatic int unsigned rand_size();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 70) return $urandom_range(1, 64);
    if (p < 85) return $urandom_range(0, 300);
    if (p < 95) return $urandom_range(0, 2047);
    return $urandom_range(1000, 1024);
  endfunction

  // stimulus fill
  initial begin
    ffba_req_t r;
    int unsigned n;
    n = 0;
    pending_reqs.push_back(mk_req(REQ_ALLOC, 0, 1023));
    pending_reqs.push_back(mk_req(REQ_ALLOC, 1025, 0));
    pending_reqs.push_back(mk_req(REQ_ALLOC, 2047, 0));
    pending_reqs.push_back(mk_req(REQ_ALLOC, 1024, 0));
    pending_reqs.push_back(mk_req(REQ_ALLOC, 1, 0));
    pending_reqs.push_back(mk_req(REQ_FREE, 0, 5));
    pending_reqs.push_back(mk_req(REQ_FREE, 2047, 1023));
    pending_reqs.push_back(mk_req(REQ_FREE, 1024, 0));
    pending_reqs.push_back(mk_req(REQ_ALLOC, 1, 0));
    pending_reqs.push_back(mk_req(REQ_ALLOC, 31, 0));
    pending_reqs.push_back(mk_req(REQ_ALLOC, 33, 0));
    pending_reqs.push_back(mk_req(REQ_FREE, 10, 5));
    pending_reqs.push_back(mk_req(REQ_ALLOC, 5, 0));
    pending_reqs.push_back(mk_req(REQ_ALLOC, 6, 0));
    pending_reqs.push_back(mk_req(REQ_FREE, 3, 1021));
    pending_reqs.push_back(mk_req(REQ_ALLOC, 1000, 0));
    pending_reqs.push_back(mk_req(REQ_FREE, 1024, 682));
    pending_reqs.push_back(mk_req(REQ_FREE, 2047, 0));
    pending_reqs.push_back(mk_req(REQ_ALLOC, 1023, 0));
    pending_reqs.push_back(mk_req(REQ_ALLOC, 1, 0));
    pending_reqs.push_back(mk_req(REQ_ALLOC, 1, 0));
    // random mix, occasional full wipe to keep the map from saturating
    while (n < 1500) begin
      if ($urandom_range(0, 99) == 0) r = mk_req(REQ_FREE, 1024, 0);
      else if ($urandom_range(0, 99) < 55) r = mk_req(REQ_ALLOC, rand_size(), $urandom);
      else r = mk_req(REQ_FREE, rand_size(), $urandom);
      pending_reqs.push_back(r);
      n++;
    end
  end

  // reset
  initial begin
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // driver: start/req change on the falling edge
  initial begin
    start = 1'b0;
    req_i = '0;
    gap_left = 0;
    stim_done = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      // request taken at previous rising edge when start && !busy
      if (start && !busy_q) begin
        void'(pending_reqs.pop_front());
        start <= 1'b0;
        gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
                                              : $urandom_range(0, 2);
      end else if (!start) begin
        if (gap_left > 0) gap_left--;
        else if (pending_reqs.size() > 0) begin
          req_i <= pending_reqs[0];
          start <= 1'b1;
        end else stim_done = 1'b1;
      end
    end
  end

  // monitor: sample at the rising edge
  always @(posedge clk_i) begin
    busy_q <= busy;
    if (rst_ni) begin
      if (start && !busy) expected_rsps.push_back(predict_alloc(req_i));
      if (done_o) begin
        if (expected_rsps.size() == 0) report_mismatch("response with no request pending");
        else begin
          ffba_rsp_t e;
          e = expected_rsps.pop_front();
          if (rsp_o.ok !== e.ok)
            report_mismatch($sformatf("ok got %0b exp %0b", rsp_o.ok, e.ok));
          if (rsp_o.block_address !== e.block_address)
            report_mismatch($sformatf("block_address got %0d exp %0d",
                                      rsp_o.block_address, e.block_address));
        end
      end
    end
  end

  // end of run and timeout
  initial begin
    err_count = 0;
    cycle_count = 0;
    while (!(stim_done && expected_rsps.size() == 0) && cycle_count < MaxCycle) begin
      @(posedge clk_i);
      cycle_count++;
    end
    if (cycle_count >= MaxCycle) begin
      $display("Regression FAIL");
    end else begin
      repeat (100) @(posedge clk_i);
      if (err_count == 0 && expected_rsps.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
    end
    $finish;
  end

endmodule
